// ----- src/plre_pkg.sv -----
// Package for the piecewise-linear ramp evaluator.
// Sizes, item codes and the controller/datapath command and status words.
// No dependencies.
package plre_pkg;

    localparam int MAX_POINTS = 16;
    localparam int VALUE_BITS = 16;
    localparam int POS_W      = 32;
    localparam int OUT_W      = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int STEP_W     = $clog2(VALUE_BITS);
    localparam int PROD_W     = VALUE_BITS + POS_W;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_EVAL   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    localparam logic [OUT_W-1:0] EMPTY_VALUE_RST = 16'd255;

    typedef enum logic [1:0] {
        RD_FIRST,
        RD_NEXT,
        RD_LAST
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_OK,
        RES_FULL,
        RES_ORDER,
        RES_EMPTY,
        RES_HIT,
        RES_LAST,
        RES_LERP
    } t_res_sel;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [VALUE_BITS-1:0]   val;
    } t_point;

    typedef struct packed {
        logic     load;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     write;
        logic     clear;
        logic     res_load;
        t_res_sel res_sel;
        logic     mul;
        logic     div_step;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       count_zero;
        logic       full;
        logic       idx_zero;
        logic       idx_last;
        logic       rd_ge_x;
        logic       rd_gt_x;
        logic       div_last;
    } t_dp_sts;

endpackage

// ----- src/plre_if.sv -----
// Valid/ready channel interfaces of the ramp evaluator: input, result, config.
// Depends on plre_pkg.
interface plre_in_if
    import plre_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              mode;
    logic signed [POS_W-1:0] position;
    logic [15:0]             point_value;

    modport source (output valid, mode, position, point_value, input ready);
    modport sink (input valid, mode, position, point_value, output ready);
endinterface

interface plre_out_if
    import plre_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] ramp_value;
    logic [1:0]       status;
    logic             clamped;

    modport source (output valid, ramp_value, status, clamped, input ready);
    modport sink (input valid, ramp_value, status, clamped, output ready);
endinterface

interface plre_cfg_if
    import plre_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] empty_value;

    modport source (output valid, empty_value, input ready);
    modport sink (input valid, empty_value, output ready);
endinterface

// ----- src/plre_ctrl.sv -----
// Sequencer of the ramp evaluator: dispatch, point search, divide, result handoff.
// Depends on plre_pkg; drives plre_dp through t_dp_cmd.
module plre_ctrl
    import plre_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_ACHK,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        cmd         = '0;
        cmd.rd_sel  = RD_FIRST;
        cmd.res_sel = RES_OK;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_state      = S_DONE;
                cmd.res_load = 1'b1;
                case (i_sts.mode)
                    MODE_APPEND: begin
                        if (i_sts.full) begin
                            cmd.res_sel = RES_FULL;
                        end else if (i_sts.count_zero) begin
                            cmd.write = 1'b1;
                        end else begin
                            cmd.res_load = 1'b0;
                            cmd.rd_en    = 1'b1;
                            cmd.rd_sel   = RD_LAST;
                            n_state      = S_ACHK;
                        end
                    end
                    MODE_EVAL: begin
                        if (i_sts.count_zero) begin
                            cmd.res_sel = RES_EMPTY;
                        end else begin
                            cmd.res_load = 1'b0;
                            cmd.rd_en    = 1'b1;
                            cmd.rd_sel   = RD_FIRST;
                            n_state      = S_SCAN;
                        end
                    end
                    MODE_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    default: begin
                        cmd.res_sel = RES_OK;
                    end
                endcase
            end
            S_ACHK: begin
                cmd.res_load = 1'b1;
                n_state      = S_DONE;
                if (i_sts.rd_gt_x) begin
                    cmd.res_sel = RES_ORDER;
                end else begin
                    cmd.write = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_sts.rd_ge_x) begin
                    if (i_sts.idx_zero) begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_HIT;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end else if (i_sts.idx_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_LAST;
                    n_state      = S_DONE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_LERP;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> r_out_valid)
        else $error("result word not presented after load");
    a_lerp_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> !i_sts.idx_zero)
        else $error("interpolation started without a lower point");
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_FIN))
        else $error("divide did not finish after its last step");
`endif

endmodule

// ----- src/plre_dp.sv -----
// Datapath of the ramp evaluator: point table, search compare, multiply,
// restoring divide, result and output words. Depends on plre_pkg.
module plre_dp
    import plre_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic [1:0]              i_mode,
    input  logic signed [POS_W-1:0] i_position,
    input  logic [15:0]             i_point_value,
    input  logic                    i_cfg_we,
    input  logic [OUT_W-1:0]        i_cfg_empty_value,
    output logic [OUT_W-1:0]        o_ramp_value,
    output logic [1:0]              o_status,
    output logic                    o_clamped
);

    t_point                  r_mem [MAX_POINTS];
    t_point                  r_rd;
    t_point                  r_prev;
    logic [IDX_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_count;
    logic [OUT_W-1:0]        r_empty;
    logic [1:0]              r_mode;
    logic signed [POS_W-1:0] r_x;
    logic [VALUE_BITS-1:0]   r_pv;
    logic [POS_W-1:0]        r_rem;
    logic [VALUE_BITS-1:0]   r_quo;
    logic [POS_W-1:0]        r_span;
    logic [VALUE_BITS-1:0]   r_v0;
    logic [VALUE_BITS-1:0]   r_dv;
    logic                    r_desc;
    logic [STEP_W-1:0]       r_step;
    logic [OUT_W-1:0]        r_res_value;
    logic [1:0]              r_res_status;
    logic                    r_res_clamped;
    logic [OUT_W-1:0]        r_out_value;
    logic [1:0]              r_out_status;
    logic                    r_out_clamped;

    logic [CNT_W-1:0]        cnt_m1;
    logic [IDX_W-1:0]        rd_addr;
    logic                    full;
    logic                    count_ge2;
    logic signed [POS_W:0]   d_full;
    logic signed [POS_W:0]   span_full;
    logic                    desc;
    logic [VALUE_BITS-1:0]   dv;
    logic [PROD_W-1:0]       prod;
    logic [POS_W:0]          div_t;
    logic [POS_W:0]          div_diff;
    logic                    div_ge;
    logic [VALUE_BITS-1:0]   lerp_val;
    logic [OUT_W-1:0]        n_res_value;
    logic [1:0]              n_res_status;
    logic                    n_res_clamped;

    assign cnt_m1    = r_count - CNT_W'(1);
    assign full      = (r_count >= CNT_W'(MAX_POINTS));
    assign count_ge2 = (r_count > CNT_W'(1));

    always_comb begin
        case (i_cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_NEXT:  rd_addr = r_idx + IDX_W'(1);
            RD_LAST:  rd_addr = cnt_m1[IDX_W-1:0];
            default:  rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[r_count[IDX_W-1:0]] <= '{pos: r_x, val: r_pv};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Interpolation terms
    assign d_full    = {r_x[POS_W-1], r_x} - {r_prev.pos[POS_W-1], r_prev.pos};
    assign span_full = {r_rd.pos[POS_W-1], r_rd.pos} - {r_prev.pos[POS_W-1], r_prev.pos};
    assign desc      = (r_rd.val < r_prev.val);
    assign dv        = desc ? (r_prev.val - r_rd.val) : (r_rd.val - r_prev.val);
    assign prod      = PROD_W'(dv) * PROD_W'(d_full[POS_W-1:0]);

    assign div_t    = {r_rem, r_quo[VALUE_BITS-1]};
    assign div_diff = div_t - {1'b0, r_span};
    assign div_ge   = (div_t >= {1'b0, r_span});
    assign lerp_val = r_desc ? (r_v0 - r_quo) : (r_v0 + r_quo);

    always_comb begin
        n_res_value   = '0;
        n_res_status  = ST_OK;
        n_res_clamped = 1'b0;
        case (i_cmd.res_sel)
            RES_OK:    n_res_status = ST_OK;
            RES_FULL:  n_res_status = ST_FULL;
            RES_ORDER: n_res_status = ST_ORDER;
            RES_EMPTY: n_res_value  = r_empty;
            RES_HIT: begin
                n_res_value   = OUT_W'(r_rd.val);
                n_res_clamped = (r_rd.pos > r_x) && count_ge2;
            end
            RES_LAST: begin
                n_res_value   = OUT_W'(r_rd.val);
                n_res_clamped = count_ge2;
            end
            RES_LERP:  n_res_value = OUT_W'(lerp_val);
            default:   n_res_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_empty <= EMPTY_VALUE_RST;
            r_step  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_empty <= i_cfg_empty_value;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.write) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.mul) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_x    <= i_position;
            r_pv   <= VALUE_BITS'(i_point_value);
        end
        if (i_cmd.rd_en) begin
            r_idx <= rd_addr;
        end
        if (i_cmd.rd_en && i_cmd.rd_sel == RD_NEXT) begin
            r_prev <= r_rd;
        end
        if (i_cmd.mul) begin
            r_rem  <= prod[PROD_W-1:VALUE_BITS];
            r_quo  <= prod[VALUE_BITS-1:0];
            r_span <= span_full[POS_W-1:0];
            r_v0   <= r_prev.val;
            r_dv   <= dv;
            r_desc <= desc;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[POS_W-1:0] : div_t[POS_W-1:0];
            r_quo <= {r_quo[VALUE_BITS-2:0], div_ge};
        end
        if (i_cmd.res_load) begin
            r_res_value   <= n_res_value;
            r_res_status  <= n_res_status;
            r_res_clamped <= n_res_clamped;
        end
        if (i_cmd.out_load) begin
            r_out_value   <= r_res_value;
            r_out_status  <= r_res_status;
            r_out_clamped <= r_res_clamped;
        end
    end

    assign o_sts.mode       = r_mode;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.full       = full;
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.idx_last   = (CNT_W'(r_idx) == cnt_m1);
    assign o_sts.rd_ge_x    = (r_rd.pos >= r_x);
    assign o_sts.rd_gt_x    = (r_rd.pos > r_x);
    assign o_sts.div_last   = (r_step == STEP_W'(VALUE_BITS - 1));

    assign o_ramp_value = r_out_value;
    assign o_status     = r_out_status;
    assign o_clamped    = r_out_clamped;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond table depth");
    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> !full)
        else $error("point written to a full table");
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_load && i_cmd.res_sel == RES_LERP) |-> (r_quo <= r_dv))
        else $error("interpolation step exceeds value difference");
`endif

endmodule

// ----- src/piecewise_linear_ramp_eval_core.sv -----
// Piecewise-linear ramp evaluator, top level.
// Channels: i_in (mode, position, point_value), o_out (ramp_value, status,
// clamped), i_cfg (empty_value write, always ready). Valid/ready words.
// Every input word gives exactly one result word, in order.
// Append: point checked against the last stored point (one table read)
// when the table is neither empty nor full. Evaluate walks the table one
// point per cycle; when the position lies between two points it then runs
// one 16x32 multiply and a 16-step restoring divide, one quotient bit per
// cycle. One word is in flight at a time; the next input is taken in the
// cycle after the result is loaded into the output register, even while
// that result still waits for o_out.ready.
// A stalled receiver holds the result word; a finished word waits in the
// datapath until the output register frees.
// Reset (i_rst_n low, synchronous): table emptied, empty_value back to 255,
// no result pending. Point storage is not cleared.
module piecewise_linear_ramp_eval_core
    import plre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    plre_in_if.sink     i_in,
    plre_out_if.source  o_out,
    plre_cfg_if.sink    i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    plre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    plre_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_in.mode),
        .i_position        (i_in.position),
        .i_point_value     (i_in.point_value),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_empty_value (i_cfg.empty_value),
        .o_ramp_value      (o_out.ramp_value),
        .o_status          (o_out.status),
        .o_clamped         (o_out.clamped)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign i_cfg.ready = 1'b1;

endmodule
